[rtl/rrl_pkg.sv]
// Shared constants and types for the round-robin run list.
package rrl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ID_W        = 15;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 2;
    localparam int ECNT_W      = 5;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PICK,
        ST_DONE
    } rrl_state_t;

endpackage

[rtl/round_robin_run_list.sv]
// Round-robin run list: ordered process id list with add, remove and pick-next.
//
// channel  dir  fields (tdata, low bit up)
// s_*      in   op[1:0], proc_id[16:2], zero fill [23:17]
// m_*      out  next_id[14:0], status[16:15], entry_count[21:17], zero fill [23:22]
//
// add, unused op and pick on an empty list go straight to the result; pick from idle
// reads entry 0; remove scans for the id, pick after a running id scans then reads the next;
// one read port walks the list one entry a cycle, remove then shifts one a cycle.
// Reset clears the count; the id store holds no reset value.
// s_tready is high only between items; a word held on m_* does not block the
// next accept, only the loading of the next result.
module round_robin_run_list
    import rrl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[1:0], proc_id[16:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // next_id[14:0], status[16:15], entry_count[21:17]
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    rrl_state_t         state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ID_W-1:0]    res_id_reg, res_id_next;
    logic [STAT_W-1:0]  res_stat_reg, res_stat_next;
    logic               out_valid_reg, out_valid_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic [STAT_W-1:0]  out_stat_reg, out_stat_next;
    logic [ECNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic [ID_W-1:0]    run_ids_reg [MAX_ENTRIES];
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ID_W-1:0]    wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [ID_W-1:0]    rd_data;
    logic [CNT_W-1:0]   idx_plus;
    logic               s_fire;
    logic [OP_W-1:0]    in_op;
    logic [ID_W-1:0]    in_id;

    assign in_op    = s_tdata[1:0];
    assign in_id    = s_tdata[16:2];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign idx_plus = idx_reg + 1'b1;
    assign rd_addr  = (state_reg == ST_SHIFT) ? idx_plus[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign rd_data  = run_ids_reg[rd_addr];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_cnt_reg, out_stat_reg, out_id_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            run_ids_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        idx_reg      <= idx_next;
        res_id_reg   <= res_id_next;
        res_stat_reg <= res_stat_next;
        out_id_reg   <= out_id_next;
        out_stat_reg <= out_stat_next;
        out_cnt_reg  <= out_cnt_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        res_id_next    = res_id_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_stat_next  = out_stat_reg;
        out_cnt_next   = out_cnt_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IDX_W-1:0];
        wr_data        = rd_data;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    op_next       = in_op;
                    id_next       = in_id;
                    idx_next      = '0;
                    res_id_next   = '0;
                    res_stat_next = STAT_OK;
                    state_next    = ST_DONE;
                    case (in_op)
                        OP_ADD:
                        begin
                            if (count_reg >= MAX_CNT)
                            begin
                                res_stat_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = in_id;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            state_next = ST_SCAN;
                        end
                        OP_PICK:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (in_id == '0)
                            begin
                                state_next = ST_PICK;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        res_stat_next = STAT_MISSING;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_PICK;
                    end
                end
                else if (rd_data == id_reg)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        idx_next   = (idx_plus < count_reg) ? idx_plus : '0;
                        state_next = ST_PICK;
                    end
                end
                else
                begin
                    idx_next = idx_plus;
                end
            end
            ST_SHIFT:
            begin
                if (idx_plus < count_reg)
                begin
                    wr_en    = 1'b1;
                    idx_next = idx_plus;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_PICK:
            begin
                res_id_next = rd_data;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_id_reg;
                    out_stat_next  = res_stat_reg;
                    out_cnt_next   = ECNT_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("run list count above capacity");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && in_op == OP_ADD && count_reg < MAX_CNT)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("add did not grow the list");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stat_reg == STAT_FULL) |-> out_cnt_reg == ECNT_W'(MAX_CNT))
        else $error("full status with list not full");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> idx_reg < count_reg)
        else $error("shift index outside the list");

endmodule

[dv/round_robin_run_list_tb.sv]
// Testbench for the round-robin run list: queued random and directed words, self-checking.
`timescale 1ns / 100ps

module round_robin_run_list_tb;
    import rrl_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int POOL_N = 12;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] proc_id;
    } sched_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]   next_id;
        logic [STAT_W-1:0] status;
        logic [ECNT_W-1:0] entry_count;
    } sched_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    sched_cmd_t  pending_cmds[$];
    sched_resp_t expected_resps[$];
    sched_cmd_t  cur_cmd;

    logic [ID_W-1:0] run_list[MAX_ENTRIES];
    int              run_len;
    logic [ID_W-1:0] id_pool[POOL_N];
    bit              filling;
    int              trend_left;
    int              src_idle_pct;
    int              snk_idle_pct;
    int              mismatch_count;

    round_robin_run_list u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // first copy of the id, or run_len when absent
    function automatic sched_resp_t run_list_step(input sched_cmd_t c);
        sched_resp_t r;
        int          pos;
        int          i;
        r = '0;
        r.status = STAT_OK;
        pos = run_len;
        for (i = run_len - 1; i >= 0; i--)
            if (run_list[i] == c.proc_id)
                pos = i;
        case (c.op)
            OP_ADD:
                if (run_len >= MAX_ENTRIES)
                    r.status = STAT_FULL;
                else
                begin
                    run_list[run_len] = c.proc_id;
                    run_len++;
                end
            OP_REMOVE:
                if (pos >= run_len)
                    r.status = STAT_MISSING;
                else
                begin
                    for (i = pos; i + 1 < run_len; i++)
                        run_list[i] = run_list[i + 1];
                    run_len--;
                end
            OP_PICK:
                if (run_len == 0)
                    r.next_id = '0;
                else if (c.proc_id == '0)
                    r.next_id = run_list[0];
                else if (pos + 1 < run_len)
                    r.next_id = run_list[pos + 1];
                else
                    r.next_id = run_list[0];
            default:
                ;
        endcase
        r.entry_count = run_len[ECNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        bit load;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            load = 1'b0;
            if (s_tvalid && s_tready)
            begin
                expected_resps.push_back(run_list_step(cur_cmd));
                load = 1'b1;
            end
            else if (!s_tvalid)
                load = 1'b1;
            if (load)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, cur_cmd.proc_id, cur_cmd.op};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        sched_resp_t got;
        sched_resp_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.next_id     = m_tdata[14:0];
                got.status      = m_tdata[16:15];
                got.entry_count = m_tdata[21:17];
                if (expected_resps.size() == 0)
                begin
                    $error("result word with nothing expected: %h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_resps.pop_front();
                    check_field("next_id", 32'(want.next_id), 32'(got.next_id));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(got.entry_count));
                end
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
        sched_cmd_t c;
        c.op = op;
        c.proc_id = id;
        pending_cmds.push_back(c);
    endtask

    // bursts alternate between growing and shrinking the list
    task automatic queue_random(input int n);
        sched_cmd_t c;
        int         roll;
        int         k;
        for (k = 0; k < n; k++)
        begin
            if (trend_left == 0)
            begin
                filling = !filling;
                trend_left = $urandom_range(8, 40);
            end
            trend_left--;
            if ($urandom_range(15) == 0)
                id_pool[$urandom_range(POOL_N - 1)] = ID_W'($urandom_range(32767));
            roll = $urandom_range(99);
            if (roll < 4)
                c.op = OP_UNUSED;
            else if (roll < 30)
                c.op = OP_PICK;
            else if (roll < (filling ? 80 : 45))
                c.op = OP_ADD;
            else
                c.op = OP_REMOVE;
            roll = $urandom_range(99);
            if (roll < 75)
                c.proc_id = id_pool[$urandom_range(POOL_N - 1)];
            else if (roll < 85)
                c.proc_id = '0;
            else
                c.proc_id = ID_W'($urandom_range(32767));
            pending_cmds.push_back(c);
        end
    endtask

    task automatic wait_drained;
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_resps.size() != 0);
    endtask

    initial
    begin
        int p;
        run_len = 0;
        mismatch_count = 0;
        filling = 1'b0;
        trend_left = 0;
        src_idle_pct = 12;
        snk_idle_pct = 78;
        id_pool[0] = '0;
        id_pool[1] = 15'h7FFF;
        for (p = 2; p < POOL_N; p++)
            id_pool[p] = ID_W'($urandom_range(32767));

        // empty list
        push_cmd(OP_PICK, 15'h0000);
        push_cmd(OP_PICK, 15'h1234);
        push_cmd(OP_REMOVE, 15'h0001);
        push_cmd(OP_UNUSED, 15'h7FFF);
        // id 0 and duplicates are stored
        push_cmd(OP_ADD, 15'h7FFF);
        push_cmd(OP_ADD, 15'h0000);
        push_cmd(OP_ADD, 15'h2AAA);
        push_cmd(OP_ADD, 15'h7FFF);
        push_cmd(OP_ADD, 15'h0001);
        push_cmd(OP_PICK, 15'h0000);
        push_cmd(OP_PICK, 15'h7FFF);
        push_cmd(OP_PICK, 15'h0001);
        push_cmd(OP_PICK, 15'h4000);
        push_cmd(OP_REMOVE, 15'h7FFF);
        push_cmd(OP_REMOVE, 15'h4000);
        push_cmd(OP_UNUSED, 15'h5555);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_random(570);
        wait_drained();

        src_idle_pct = 78;
        snk_idle_pct = 12;
        queue_random(570);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_random(570);
        wait_drained();

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_resps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/rrl_pkg.sv
rtl/round_robin_run_list.sv
dv/round_robin_run_list_tb.sv
